[hw/rtl/asa_pkg.sv]
`timescale 1ns / 1ps

package asa_pkg;

  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned RATE_W     = 19;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned CLK_W      = 40;
  localparam int unsigned DIFF_W     = 41;
  localparam int unsigned WANT_W     = 17;
  localparam int unsigned ACC_W      = 50;
  localparam int unsigned MAG_W      = 49;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 19;
  localparam int unsigned MUL_W      = 33;
  localparam int unsigned PROD_W     = 2 * MUL_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SAMPLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_COEF        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOSYNC_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_IS_MASTER = 3'd5;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 16'd1024;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 19'd48000;
  localparam logic [COEF_W-1:0]  COEF_RESET  = 16'd52057;
  localparam logic [THR_W-1:0]   THR_RESET   = 16'd10000;

  localparam logic [CNT_W-1:0]        AVG_SAMPLES  = 5'd20;
  localparam logic [37:0]             MEAN_LIMIT   = 38'h32_0000_0000;
  localparam logic signed [ACC_W-1:0] ACC_MAX      = 50'sh1_FFFF_FFFF_FFFF;
  localparam logic [MUL_W-1:0]        DIV125_RECIP = 33'h1_0624_DD30;
  localparam logic [15:0]             DIV10_RECIP  = 16'hCCCD;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAG,
    OP_CLEAR,
    OP_NOM,
    OP_MUL_AH,
    OP_MUL_AL,
    OP_UPDATE,
    OP_MUL_KH,
    OP_MUL_KL,
    OP_MUL_DR,
    OP_MUL_DQ,
    OP_MUL_DF,
    OP_ADJ
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   push;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic invalid;
    logic in_range;
    logic cnt_full;
    logic big;
  } dp_status_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_samples;
    logic [RATE_W-1:0]  sample_rate;
    logic [COEF_W-1:0]  avg_coef;
    logic [THR_W-1:0]   nosync_threshold_ms;
    logic               sync_enable;
    logic               track_is_master;
  } cfg_t;

endpackage

[hw/rtl/asa_if.sv]
`timescale 1ns / 1ps

interface asa_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [asa_pkg::CLK_W-1:0] track_clock_ms;
  logic                            track_clock_valid;
  logic signed [asa_pkg::CLK_W-1:0] master_clock_ms;
  logic                            master_clock_valid;

  modport source (
    output valid, track_clock_ms, track_clock_valid, master_clock_ms, master_clock_valid,
    input  ready
  );
  modport sink (
    input  valid, track_clock_ms, track_clock_valid, master_clock_ms, master_clock_valid,
    output ready
  );
endinterface

interface asa_out_if;
  logic                        valid;
  logic                        ready;
  logic [asa_pkg::WANT_W-1:0]  want_samples;

  modport source (
    output valid, want_samples,
    input  ready
  );
  modport sink (
    input  valid, want_samples,
    output ready
  );
endinterface

[hw/rtl/asa_ctrl.sv]
`timescale 1ns / 1ps

module asa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  asa_pkg::dp_status_t status_i,
  output asa_pkg::dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_NOM   = 4'd3;
  localparam logic [3:0] S_MA    = 4'd4;
  localparam logic [3:0] S_MB    = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_KMAG  = 4'd7;
  localparam logic [3:0] S_KH    = 4'd8;
  localparam logic [3:0] S_KL    = 4'd9;
  localparam logic [3:0] S_KCMP  = 4'd10;
  localparam logic [3:0] S_DR    = 4'd11;
  localparam logic [3:0] S_DQ    = 4'd12;
  localparam logic [3:0] S_DF    = 4'd13;
  localparam logic [3:0] S_DC    = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = asa_pkg::OP_NONE;
    cmd_o.push  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.op = asa_pkg::OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.op = asa_pkg::OP_MAG;
        if (status_i.bypass) begin
          state_d = S_NOM;
        end else if (status_i.invalid) begin
          state_d = S_CLEAR;
        end else if (!status_i.in_range) begin
          state_d = S_NOM;
        end else begin
          state_d = S_MA;
        end
      end
      S_CLEAR: begin
        cmd_o.op = asa_pkg::OP_CLEAR;
        state_d  = S_NOM;
      end
      S_NOM: begin
        cmd_o.op = asa_pkg::OP_NOM;
        state_d  = S_OUT;
      end
      S_MA: begin
        cmd_o.op = asa_pkg::OP_MUL_AH;
        state_d  = S_MB;
      end
      S_MB: begin
        cmd_o.op = asa_pkg::OP_MUL_AL;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = asa_pkg::OP_UPDATE;
        state_d  = status_i.cnt_full ? S_KMAG : S_NOM;
      end
      S_KMAG: begin
        cmd_o.op = asa_pkg::OP_MAG;
        state_d  = S_KH;
      end
      S_KH: begin
        cmd_o.op = asa_pkg::OP_MUL_KH;
        state_d  = S_KL;
      end
      S_KL: begin
        cmd_o.op = asa_pkg::OP_MUL_KL;
        state_d  = S_KCMP;
      end
      S_KCMP: begin
        state_d = status_i.big ? S_DR : S_NOM;
      end
      S_DR: begin
        cmd_o.op = asa_pkg::OP_MUL_DR;
        state_d  = S_DQ;
      end
      S_DQ: begin
        cmd_o.op = asa_pkg::OP_MUL_DQ;
        state_d  = S_DF;
      end
      S_DF: begin
        cmd_o.op = asa_pkg::OP_MUL_DF;
        state_d  = S_DC;
      end
      S_DC: begin
        cmd_o.op = asa_pkg::OP_ADJ;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_fire_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_CHECK)
    else $error("accepted item did not advance to the check step");

  a_push_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> out_valid_q && state_q == S_IDLE)
    else $error("pushed result not presented");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("waiting result dropped");
`endif

endmodule

[hw/rtl/asa_dp.sv]
`timescale 1ns / 1ps

module asa_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  asa_pkg::cfg_t                       cfg_i,
  input  asa_pkg::dp_cmd_t                    cmd_i,
  input  logic signed [asa_pkg::CLK_W-1:0]    track_clock_ms_i,
  input  logic                                track_clock_valid_i,
  input  logic signed [asa_pkg::CLK_W-1:0]    master_clock_ms_i,
  input  logic                                master_clock_valid_i,
  output asa_pkg::dp_status_t                 status_o,
  output logic [asa_pkg::WANT_W-1:0]          want_samples_o
);

  logic signed [asa_pkg::DIFF_W-1:0] diff_q;
  logic                              trk_valid_q, mst_valid_q;
  logic [asa_pkg::MAG_W-1:0]         mag_q;
  logic                              neg_q;
  logic [asa_pkg::PROD_W-1:0]        prod_q, sum_q;
  logic signed [asa_pkg::ACC_W-1:0]  acc_q;
  logic [asa_pkg::CNT_W-1:0]         cnt_q;
  logic [asa_pkg::WANT_W-1:0]        want_q, res_q;

  logic [asa_pkg::DIFF_W-1:0]        diff_neg, diff_mag;
  logic [asa_pkg::ACC_W-1:0]         acc_neg;
  logic [asa_pkg::MAG_W-1:0]         acc_mag;
  logic [16:0]                       k_w;
  logic [asa_pkg::MUL_W-1:0]         mul_a, mul_b;
  logic [asa_pkg::PROD_W-1:0]        prod_d;
  logic [asa_pkg::MAG_W-1:0]         p_w;
  logic signed [asa_pkg::ACC_W:0]    p_s, acc_sum, diff_sh, acc_hi, acc_lo;
  logic signed [asa_pkg::ACC_W-1:0]  acc_sat;
  logic [66:0]                       mean_tot;
  logic [12:0]                       allow_w, adj_mag;
  logic [25:0]                       quot_w;
  logic [asa_pkg::WANT_W-1:0]        frame_ext, want_adj;
  logic                              is_mul;

  assign diff_neg = '0 - diff_q;
  assign diff_mag = diff_q[asa_pkg::DIFF_W-1] ? diff_neg : diff_q;
  assign acc_neg  = '0 - acc_q;
  assign acc_mag  = acc_q[asa_pkg::ACC_W-1] ? acc_neg[asa_pkg::MAG_W-1:0]
                                            : acc_q[asa_pkg::MAG_W-1:0];
  assign k_w      = 17'h1_0000 - {1'b0, cfg_i.avg_coef};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    is_mul = 1'b1;
    case (cmd_i.op)
      asa_pkg::OP_MUL_AH: begin
        mul_a = mag_q[48:16];
        mul_b = {17'b0, cfg_i.avg_coef};
      end
      asa_pkg::OP_MUL_AL: begin
        mul_a = {17'b0, mag_q[15:0]};
        mul_b = {17'b0, cfg_i.avg_coef};
      end
      asa_pkg::OP_MUL_KH: begin
        mul_a = mag_q[48:16];
        mul_b = {16'b0, k_w};
      end
      asa_pkg::OP_MUL_KL: begin
        mul_a = {17'b0, mag_q[15:0]};
        mul_b = {16'b0, k_w};
      end
      asa_pkg::OP_MUL_DR: begin
        mul_a = {17'b0, diff_mag[15:0]};
        mul_b = {14'b0, cfg_i.sample_rate};
      end
      asa_pkg::OP_MUL_DQ: begin
        mul_a = {1'b0, prod_q[34:3]};
        mul_b = asa_pkg::DIV125_RECIP;
      end
      asa_pkg::OP_MUL_DF: begin
        mul_a = {17'b0, cfg_i.frame_samples};
        mul_b = {17'b0, asa_pkg::DIV10_RECIP};
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign p_w     = sum_q[asa_pkg::MAG_W-1:0] + {33'b0, prod_q[31:16]};
  assign p_s     = $signed({2'b00, p_w});
  assign diff_sh = $signed({{18{diff_q[16]}}, diff_q[16:0], 16'b0});
  assign acc_sum = (neg_q ? -p_s : p_s) + diff_sh;
  assign acc_hi  = $signed({1'b0, asa_pkg::ACC_MAX});
  assign acc_lo  = -acc_hi;

  always_comb begin
    if (acc_sum > acc_hi) begin
      acc_sat = asa_pkg::ACC_MAX;
    end else if (acc_sum < acc_lo) begin
      acc_sat = -asa_pkg::ACC_MAX;
    end else begin
      acc_sat = acc_sum[asa_pkg::ACC_W-1:0];
    end
  end

  assign mean_tot = {1'b0, sum_q[49:0], 16'b0} + {34'b0, prod_q[32:0]};

  assign quot_w    = sum_q[25:0];
  assign allow_w   = prod_q[31:19];
  assign adj_mag   = (quot_w > {13'b0, allow_w}) ? allow_w : quot_w[12:0];
  assign frame_ext = {1'b0, cfg_i.frame_samples};
  assign want_adj  = diff_q[asa_pkg::DIFF_W-1] ? frame_ext - {4'b0, adj_mag}
                                               : frame_ext + {4'b0, adj_mag};

  assign status_o.bypass   = !cfg_i.sync_enable || cfg_i.track_is_master;
  assign status_o.invalid  = !trk_valid_q || !mst_valid_q;
  assign status_o.in_range = diff_mag < {25'b0, cfg_i.nosync_threshold_ms};
  assign status_o.cnt_full = (cnt_q >= asa_pkg::AVG_SAMPLES);
  assign status_o.big      = mean_tot > {29'b0, asa_pkg::MEAN_LIMIT};

  assign want_samples_o = res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == asa_pkg::OP_LOAD) begin
      diff_q      <= $signed({track_clock_ms_i[asa_pkg::CLK_W-1], track_clock_ms_i})
                   - $signed({master_clock_ms_i[asa_pkg::CLK_W-1], master_clock_ms_i});
      trk_valid_q <= track_clock_valid_i;
      mst_valid_q <= master_clock_valid_i;
    end
    if (cmd_i.op == asa_pkg::OP_MAG) begin
      mag_q <= acc_mag;
      neg_q <= acc_q[asa_pkg::ACC_W-1];
    end
    if (is_mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.op == asa_pkg::OP_MUL_AL || cmd_i.op == asa_pkg::OP_MUL_KL) begin
      sum_q <= prod_q;
    end else if (cmd_i.op == asa_pkg::OP_MUL_DF) begin
      sum_q <= {40'b0, prod_q[64:39]};
    end
    if (cmd_i.op == asa_pkg::OP_NOM) begin
      want_q <= frame_ext;
    end else if (cmd_i.op == asa_pkg::OP_ADJ) begin
      want_q <= want_adj;
    end
    if (cmd_i.push) begin
      res_q <= want_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.op == asa_pkg::OP_CLEAR) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.op == asa_pkg::OP_UPDATE) begin
      acc_q <= acc_sat;
      if (cnt_q < asa_pkg::AVG_SAMPLES) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == asa_pkg::OP_UPDATE |=>
      acc_q <= asa_pkg::ACC_MAX && acc_q >= -asa_pkg::ACC_MAX)
    else $error("accumulator outside saturation bound");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == asa_pkg::OP_CLEAR |=> acc_q == '0 && cnt_q == '0)
    else $error("averaging state not cleared");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == asa_pkg::OP_UPDATE && cnt_q < asa_pkg::AVG_SAMPLES |=>
      cnt_q == $past(cnt_q) + 5'd1)
    else $error("sample count did not advance");
`endif

endmodule

[hw/rtl/audio_sync_sample_adjust_top.sv]
`timescale 1ns / 1ps

// Decides how many samples each audio output buffer carries so the track clock
// follows a master clock. One item (track and master clock in ms with their
// valid flags) gives one result, want_samples. The result is loaded into the
// output register after the check and nominal steps when sync is off, the
// track is master or the difference is large, after an added clear step when a
// clock is invalid, after the accumulator update while the averager is still
// filling, after the mean test as well when the running mean stays within
// limit, and after the full path that also scales the difference by the sample
// rate; the controller steps one shared 33x33 multiplier through the
// accumulator update, the mean test and the rate scaling. The next item is
// taken in the cycle after the result is loaded; loading waits while the
// previous result still sits in the output register for the sink.
// Configuration writes are taken at any cycle but belong to idle periods;
// there is no clearing pass after reset.
module audio_sync_sample_adjust_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [asa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [asa_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  asa_in_if.sink                              in_i,
  asa_out_if.source                           out_o
);

  asa_pkg::cfg_t       cfg_q;
  asa_pkg::dp_cmd_t    cmd;
  asa_pkg::dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_samples       <= asa_pkg::FRAME_RESET;
      cfg_q.sample_rate         <= asa_pkg::RATE_RESET;
      cfg_q.avg_coef            <= asa_pkg::COEF_RESET;
      cfg_q.nosync_threshold_ms <= asa_pkg::THR_RESET;
      cfg_q.sync_enable         <= 1'b1;
      cfg_q.track_is_master     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asa_pkg::REG_FRAME_SAMPLES:   cfg_q.frame_samples       <= cfg_data_i[15:0];
        asa_pkg::REG_SAMPLE_RATE:     cfg_q.sample_rate         <= cfg_data_i;
        asa_pkg::REG_AVG_COEF:        cfg_q.avg_coef            <= cfg_data_i[15:0];
        asa_pkg::REG_NOSYNC_THRESH:   cfg_q.nosync_threshold_ms <= cfg_data_i[15:0];
        asa_pkg::REG_SYNC_ENABLE:     cfg_q.sync_enable         <= cfg_data_i[0];
        asa_pkg::REG_TRACK_IS_MASTER: cfg_q.track_is_master     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  asa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  asa_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .cmd_i                (cmd),
    .track_clock_ms_i     (in_i.track_clock_ms),
    .track_clock_valid_i  (in_i.track_clock_valid),
    .master_clock_ms_i    (in_i.master_clock_ms),
    .master_clock_valid_i (in_i.master_clock_valid),
    .status_o             (status),
    .want_samples_o       (out_o.want_samples)
  );

endmodule

[sim/tb_audio_sync_sample_adjust_top.sv]
`timescale 1ns / 1ps

module tb_audio_sync_sample_adjust_top;

  localparam int     WARMUP_ITEMS  = 20;
  localparam longint MEAN_LIMIT_MS = 50;
  localparam longint ACC_SAT       = 64'sd562949953421311;
  localparam logic signed [asa_pkg::CLK_W-1:0] CLK_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [asa_pkg::CLK_W-1:0] CLK_MIN = 40'sh80_0000_0000;

  typedef struct {
    logic signed [asa_pkg::CLK_W-1:0] track_ms;
    logic                             track_ok;
    logic signed [asa_pkg::CLK_W-1:0] master_ms;
    logic                             master_ok;
  } clk_pair_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [asa_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [asa_pkg::CFG_DATA_W-1:0] cfg_data_i;

  asa_in_if  in_bus ();
  asa_out_if out_bus ();

  audio_sync_sample_adjust_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  logic [asa_pkg::FRAME_W-1:0] frame_r;
  logic [asa_pkg::RATE_W-1:0]  rate_r;
  logic [asa_pkg::COEF_W-1:0]  coef_r;
  logic [asa_pkg::THR_W-1:0]   thr_r;
  logic                        sync_en_r;
  logic                        is_master_r;
  longint                      accum_q;
  int                          avg_cnt;

  logic [asa_pkg::WANT_W-1:0] want_q [$];
  int                         errors;
  int                         send_gap_pct;
  int                         recv_gap_pct;
  int                         hold_len;
  int                         hold_seq;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint mag_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [asa_pkg::WANT_W-1:0] predict_want(input clk_pair_t it);
    longint frame, rate, coef, thr, want, diff, mag, prod, acc, adj, allow, lim;
    frame = frame_r;
    rate  = rate_r;
    coef  = coef_r;
    thr   = thr_r;
    want  = frame;
    if (sync_en_r && !is_master_r) begin
      if (!it.track_ok || !it.master_ok) begin
        accum_q = 0;
        avg_cnt = 0;
      end else begin
        diff = longint'(it.track_ms) - longint'(it.master_ms);
        if (mag_of(diff) < thr) begin
          mag  = mag_of(accum_q);
          prod = coef * (mag / 65536) + (coef * (mag % 65536)) / 65536;
          acc  = (accum_q < 0) ? -prod : prod;
          acc  = acc + diff * 65536;
          if (acc > ACC_SAT) acc = ACC_SAT;
          if (acc < -ACC_SAT) acc = -ACC_SAT;
          accum_q = acc;
          if (avg_cnt < WARMUP_ITEMS) begin
            avg_cnt++;
          end else begin
            lim = (MEAN_LIMIT_MS <<< 32) / (65536 - coef);
            if (mag_of(accum_q) > lim) begin
              adj   = diff * rate / 1000;
              allow = frame / 10;
              if (adj > allow) adj = allow;
              if (adj < -allow) adj = -allow;
              want = frame + adj;
            end
          end
        end
      end
    end
    return want[asa_pkg::WANT_W-1:0];
  endfunction

  function automatic clk_pair_t pair_of(input logic signed [asa_pkg::CLK_W-1:0] t,
                                        input logic signed [asa_pkg::CLK_W-1:0] m,
                                        input logic tv, input logic mv);
    clk_pair_t it;
    it.track_ms  = t;
    it.master_ms = m;
    it.track_ok  = tv;
    it.master_ok = mv;
    return it;
  endfunction

  function automatic clk_pair_t valid_pair(input longint diff);
    logic [63:0] r;
    logic signed [asa_pkg::CLK_W-1:0] t;
    r = {$urandom, $urandom};
    t = r[asa_pkg::CLK_W-1:0];
    return pair_of(t, t - diff[asa_pkg::CLK_W-1:0], 1'b1, 1'b1);
  endfunction

  function automatic clk_pair_t noise_pair(input bit any_flags);
    logic [63:0] rt, rm;
    rt = {$urandom, $urandom};
    rm = {$urandom, $urandom};
    return pair_of(rt[asa_pkg::CLK_W-1:0], rm[asa_pkg::CLK_W-1:0],
                   any_flags ? 1'($urandom_range(1)) : 1'b1,
                   any_flags ? 1'($urandom_range(1)) : 1'b1);
  endfunction

  task automatic send_item(input clk_pair_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid              <= 1'b1;
    in_bus.track_clock_ms     <= it.track_ms;
    in_bus.track_clock_valid  <= it.track_ok;
    in_bus.master_clock_ms    <= it.master_ms;
    in_bus.master_clock_valid <= it.master_ok;
    do @(posedge clk_i); while (!in_bus.ready);
    want_q.push_back(predict_want(it));
  endtask

  task automatic send_run(input int n, input longint diff);
    for (int k = 0; k < n; k++) send_item(valid_pair(diff));
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [asa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [asa_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      asa_pkg::REG_FRAME_SAMPLES:   frame_r     = data[asa_pkg::FRAME_W-1:0];
      asa_pkg::REG_SAMPLE_RATE:     rate_r      = data[asa_pkg::RATE_W-1:0];
      asa_pkg::REG_AVG_COEF:        coef_r      = data[asa_pkg::COEF_W-1:0];
      asa_pkg::REG_NOSYNC_THRESH:   thr_r       = data[asa_pkg::THR_W-1:0];
      asa_pkg::REG_SYNC_ENABLE:     sync_en_r   = data[0];
      asa_pkg::REG_TRACK_IS_MASTER: is_master_r = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [asa_pkg::FRAME_W-1:0] frame,
                                input logic [asa_pkg::RATE_W-1:0] rate,
                                input logic [asa_pkg::COEF_W-1:0] coef,
                                input logic [asa_pkg::THR_W-1:0] thr,
                                input logic sync_en, input logic is_master);
    drain_results();
    write_reg(asa_pkg::REG_FRAME_SAMPLES, {3'b0, frame});
    write_reg(asa_pkg::REG_SAMPLE_RATE, rate);
    write_reg(asa_pkg::REG_AVG_COEF, {3'b0, coef});
    write_reg(asa_pkg::REG_NOSYNC_THRESH, {3'b0, thr});
    write_reg(asa_pkg::REG_SYNC_ENABLE, {18'b0, sync_en});
    write_reg(asa_pkg::REG_TRACK_IS_MASTER, {18'b0, is_master});
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(pair_of(CLK_MAX, CLK_MIN, 1'b0, 1'b0));
    send_item(pair_of(CLK_MIN, CLK_MAX, 1'b0, 1'b1));
    send_item(pair_of(CLK_MAX, CLK_MAX, 1'b1, 1'b0));
    send_item(pair_of(CLK_MAX, CLK_MIN, 1'b1, 1'b1));
    send_item(pair_of(CLK_MIN, CLK_MAX, 1'b1, 1'b1));
    send_item(valid_pair(10000));
    send_item(valid_pair(-10000));
    send_item(valid_pair(-9999));
    send_run(20, 300);
    send_run(2, -300);
    send_run(2, 1);
  endtask

  task automatic test_special_settings();
    apply_settings(asa_pkg::FRAME_RESET, asa_pkg::RATE_RESET, asa_pkg::COEF_RESET,
                   asa_pkg::THR_RESET, 1'b1, 1'b1);
    send_item(valid_pair(300));
    send_item(noise_pair(1'b1));
    apply_settings(asa_pkg::FRAME_RESET, asa_pkg::RATE_RESET, asa_pkg::COEF_RESET,
                   asa_pkg::THR_RESET, 1'b0, 1'b0);
    send_item(valid_pair(-300));
    send_item(pair_of(CLK_MAX, CLK_MIN, 1'b0, 1'b0));
    apply_settings(asa_pkg::FRAME_RESET, asa_pkg::RATE_RESET, asa_pkg::COEF_RESET,
                   16'd0, 1'b1, 1'b0);
    send_item(valid_pair(0));
    send_item(valid_pair(5));
    apply_settings(16'd0, asa_pkg::RATE_RESET, asa_pkg::COEF_RESET,
                   asa_pkg::THR_RESET, 1'b1, 1'b0);
    send_run(2, 300);
    apply_settings(asa_pkg::FRAME_RESET, 19'd0, asa_pkg::COEF_RESET,
                   asa_pkg::THR_RESET, 1'b1, 1'b0);
    send_run(2, 300);
    apply_settings(asa_pkg::FRAME_RESET, asa_pkg::RATE_RESET, asa_pkg::COEF_RESET,
                   asa_pkg::THR_RESET, 1'b1, 1'b0);
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    hold_seq++;
    send_run(24, 120);
    drain_results();
  endtask

  task automatic test_pause_resume();
    send_run(10, -80);
    drain_results();
    send_run(15, -80);
    drain_results();
  endtask

  task automatic run_random_phase(input int n_items);
    int     sent, len, roll;
    longint base, spread, lim_d;
    sent = 0;
    while (sent < n_items) begin
      lim_d = thr_r;
      if (lim_d > 0) lim_d--;
      if ($urandom_range(1)) base = $urandom_range(0, 200);
      else base = $urandom_range(0, int'(lim_d));
      if ($urandom_range(1)) base = -base;
      spread = $urandom_range(0, 20);
      len    = $urandom_range(20, 40);
      for (int k = 0; k < len && sent < n_items; k++) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_item(noise_pair(1'b1));
        end else if (roll < 8) begin
          send_item(noise_pair(1'b0));
        end else begin
          send_item(valid_pair(base + longint'($urandom_range(0, int'(2 * spread))) - spread));
        end
        sent++;
      end
    end
  endtask

  task automatic random_settings();
    apply_settings(16'($urandom_range(1, 65535)), 19'($urandom_range(1, 384000)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   $urandom_range(7) != 0, $urandom_range(7) == 0);
  endtask

  task automatic check_want(input logic [asa_pkg::WANT_W-1:0] got);
    logic [asa_pkg::WANT_W-1:0] exp_want;
    if (want_q.size() == 0) begin
      $display("%0t want_samples unexpected: expected none actual %0d", $time, got);
      errors++;
    end else begin
      exp_want = want_q.pop_front();
      if (got !== exp_want) begin
        $display("%0t want_samples mismatch: expected %0d actual %0d", $time, exp_want, got);
        errors++;
      end
    end
  endtask

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) check_want(out_bus.want_samples);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  initial begin
    errors      = 0;
    hold_len    = 0;
    hold_seq    = 0;
    frame_r     = asa_pkg::FRAME_RESET;
    rate_r      = asa_pkg::RATE_RESET;
    coef_r      = asa_pkg::COEF_RESET;
    thr_r       = asa_pkg::THR_RESET;
    sync_en_r   = 1'b1;
    is_master_r = 1'b0;
    accum_q     = 0;
    avg_cnt     = 0;
    send_gap_pct = 12;
    recv_gap_pct = 51;

    rst_ni                    <= 1'b0;
    cfg_we_i                  <= 1'b0;
    cfg_idx_i                 <= asa_pkg::REG_FRAME_SAMPLES;
    cfg_data_i                <= '0;
    in_bus.valid              <= 1'b0;
    in_bus.track_clock_ms     <= '0;
    in_bus.track_clock_valid  <= 1'b0;
    in_bus.master_clock_ms    <= '0;
    in_bus.master_clock_valid <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_special_settings();
    test_backpressure();
    test_pause_resume();

    run_random_phase(50);
    apply_settings(16'd65535, 19'd384000, 16'd65535, 16'd65535, 1'b1, 1'b0);
    run_random_phase(50);

    send_gap_pct = 51;
    recv_gap_pct = 12;
    apply_settings(16'd1, 19'd1, 16'd0, 16'd1, 1'b1, 1'b0);
    run_random_phase(50);
    random_settings();
    run_random_phase(50);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    apply_settings(16'd65535, 19'd384000, 16'd0, 16'd65535, 1'b1, 1'b0);
    run_random_phase(50);
    random_settings();
    run_random_phase(50);

    drain_results();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/asa_pkg.sv
hw/rtl/asa_if.sv
hw/rtl/asa_ctrl.sv
hw/rtl/asa_dp.sv
hw/rtl/audio_sync_sample_adjust_top.sv
sim/tb_audio_sync_sample_adjust_top.sv
